/* src/zmm_pkg.sv */
// Shared widths, constants, codes and control structs for the zonal masked mean block.
`default_nettype none

package zmm_pkg;

    localparam int NZONES      = 4;
    localparam int ZONE_W      = $clog2(NZONES);
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int VAL_W       = 16;
    localparam int OFFICE_W    = 8;
    localparam int MASK_W      = NZONES;
    localparam int SUM_W       = 27;
    localparam int CNT_W       = 13;
    localparam int FRAC_W      = 8;
    localparam int MEAN_W      = 24;
    // spare top bit takes the carry of the rounding half on a saturated sum
    localparam int DIV_W       = SUM_W + FRAC_W + 1;
    localparam int STEP_W      = $clog2(DIV_W);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = NZONES * MEAN_W;

    // input word layout, lowest bit first
    localparam int X_LSB      = 0;
    localparam int Y_LSB      = X_LSB + COORD_W;
    localparam int VAL_LSB    = Y_LSB + COORD_W;
    localparam int MASK_LSB   = VAL_LSB + VAL_W;
    localparam int OWNER_LSB  = MASK_LSB + MASK_W;
    localparam int PRIOR_BIT  = OWNER_LSB + OFFICE_W;

    localparam logic [SUM_W-1:0]         SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]         CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [DIV_W-1:0]         MEAN_MAX   = DIV_W'(8388352);
    localparam logic signed [MEAN_W-1:0] MEAN_EMPTY = -MEAN_W'(25600);
    localparam logic [DIM_W-1:0]         DIM_RESET  = DIM_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMIT_ALL     = 3'd0,
        CFG_LOCAL_OFFICE = 3'd1,
        CFG_ORIGIN_X     = 3'd2,
        CFG_ORIGIN_Y     = 3'd3,
        CFG_COLUMNS      = 3'd4,
        CFG_ROWS         = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_LOAD,
        ST_STEP,
        ST_STORE,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic              acc_en;
        logic              clear;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic              out_load;
        logic [ZONE_W-1:0] zone;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* src/zonal_masked_mean.sv */
// Top level of the zonal masked mean block: controller, datapath and checks.
//
// Per-basin mean of a grid value over four elevation zones.
// Slave stream: one word per grid point, one word a cycle while accumulating.
//   tlast marks the final word of a basin; tuser[0] says the word carries a point.
// Config channel: cfg_index selects a register (0 emit_all .. 5 grid_rows),
//   cfg_data is the value; always ready, write only while the block is idle.
// Master stream: one 96-bit word of four 24-bit zone means per basin, zone 0 lowest,
//   unless the ownership skip rule holds on the final word.
// Sequence: after the final word of an unskipped basin the shared restoring divider
//   runs, for each of the four zones in turn, one load, 36 bit steps and one store;
//   then the means move into the output register once it is free, which raises
//   m_tvalid; the slave side is stalled meanwhile.
// The output register lets the next basin stream in while a result waits; if a
//   second basin finishes before the first result is taken, the block holds
//   until m_tready frees the register.
// Reset: accumulators cleared, grid registers to origin 0 and 4096 x 4096,
//   emit_all 0, local_office 0; no result pending.
`default_nettype none

module zonal_masked_mean (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // x[11:0], y[23:12], point_value[39:24], zone_mask[43:40], basin_owner[51:44],
    // prior_all_missing[52], zero[55:53]
    input  wire logic [zmm_pkg::IN_TDATA_W-1:0]       s_tdata,
    // has_point[0]
    input  wire logic [zmm_pkg::IN_TUSER_W-1:0]       s_tuser,
    input  wire logic                                 s_tlast,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // zone0_mean[23:0], zone1_mean[47:24], zone2_mean[71:48], zone3_mean[95:72]
    output logic [zmm_pkg::OUT_TDATA_W-1:0]           m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [zmm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [zmm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import zmm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    zmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    zmm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    // the output register is only overwritten once its word has gone
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while a word is pending");

    // a rendered basin end stalls the slave side while the divider runs
    a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast && !status.skip) |=> !s_tready)
        else $error("slave side accepted during division");

    // a new result appears only from a load of the output register
    a_rise_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result word raised without a load");

    // accumulators are cleared when a result leaves the divider
    a_clear_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> cmd.clear)
        else $error("accumulators not cleared at result load");

endmodule

`default_nettype wire

/* src/zmm_ctrl.sv */
// Controller: input acceptance, per-zone division sequencing and output hand-off.
`default_nettype none

module zmm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    input  wire logic            s_tlast,
    output logic                 s_tready,
    input  wire zmm_pkg::status_t status,
    output zmm_pkg::cmd_t        cmd
);
    import zmm_pkg::*;

    state_t              state_reg, state_next;
    logic [ZONE_W-1:0]   zone_reg, zone_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            zone_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            zone_reg  <= zone_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        zone_next     = zone_reg;
        step_next     = step_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.zone      = zone_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.acc_en = 1'b1;
                    if (s_tlast)
                    begin
                        if (status.skip)
                            cmd.clear = 1'b1;
                        else
                        begin
                            zone_next  = '0;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                    state_next = ST_STORE;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_STORE:
            begin
                cmd.div_store = 1'b1;
                if (zone_reg == ZONE_W'(NZONES - 1))
                    state_next = ST_WAIT;
                else
                begin
                    zone_next  = zone_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_WAIT:
            begin
                // previous word must be gone before the new means go out
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/zmm_datapath.sv */
// Datapath: config registers, zone accumulators, shared serial divider, output register.
`default_nettype none

module zmm_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    input  wire logic [zmm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [zmm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic [zmm_pkg::IN_TDATA_W-1:0]        s_tdata,
    input  wire logic [zmm_pkg::IN_TUSER_W-1:0]        s_tuser,
    input  wire logic                                  m_tready,
    output logic                                       m_tvalid,
    output logic [zmm_pkg::OUT_TDATA_W-1:0]            m_tdata,
    input  wire zmm_pkg::cmd_t                         cmd,
    output zmm_pkg::status_t                           status
);
    import zmm_pkg::*;

    logic                emit_all_reg;
    logic [OFFICE_W-1:0] local_office_reg;
    logic [COORD_W-1:0]  origin_x_reg;
    logic [COORD_W-1:0]  origin_y_reg;
    logic [DIM_W-1:0]    columns_reg;
    logic [DIM_W-1:0]    rows_reg;

    logic [SUM_W-1:0]    sum_reg  [NZONES];
    logic [SUM_W-1:0]    sum_next [NZONES];
    logic [CNT_W-1:0]    cnt_reg  [NZONES];
    logic [CNT_W-1:0]    cnt_next [NZONES];

    logic [DIV_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    divisor_reg;
    logic                empty_reg;
    logic signed [MEAN_W-1:0] mean_reg [NZONES];

    logic                out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [COORD_W-1:0]  px, py;
    logic [VAL_W-1:0]    pval;
    logic [MASK_W-1:0]   pmask;
    logic [OFFICE_W-1:0] powner;
    logic                pprior;
    logic                phas;
    logic                qual;
    logic [COORD_W-1:0]  off_x, off_y;
    logic [SUM_W:0]      sum_wide [NZONES];
    logic [CNT_W:0]      trial;
    logic                trial_ge;
    logic [DIV_W-1:0]    dividend;

    assign px     = s_tdata[X_LSB +: COORD_W];
    assign py     = s_tdata[Y_LSB +: COORD_W];
    assign pval   = s_tdata[VAL_LSB +: VAL_W];
    assign pmask  = s_tdata[MASK_LSB +: MASK_W];
    assign powner = s_tdata[OWNER_LSB +: OFFICE_W];
    assign pprior = s_tdata[PRIOR_BIT];
    assign phas   = s_tuser[0];

    assign off_x = px - origin_x_reg;
    assign off_y = py - origin_y_reg;
    assign qual  = phas && !pval[VAL_W-1]
                 && (px >= origin_x_reg) && (py >= origin_y_reg)
                 && ({1'b0, off_x} < columns_reg) && ({1'b0, off_y} < rows_reg);

    assign status.skip     = !emit_all_reg && (powner != local_office_reg) && pprior;
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_all_reg     <= 1'b0;
            local_office_reg <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            columns_reg      <= DIM_RESET;
            rows_reg         <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EMIT_ALL:     emit_all_reg     <= cfg_data[0];
                CFG_LOCAL_OFFICE: local_office_reg <= cfg_data[OFFICE_W-1:0];
                CFG_ORIGIN_X:     origin_x_reg     <= cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data[COORD_W-1:0];
                CFG_COLUMNS:      columns_reg      <= cfg_data[DIM_W-1:0];
                CFG_ROWS:         rows_reg         <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // one saturating adder and counter per zone
    always_comb
    begin
        for (int k = 0; k < NZONES; k++)
        begin
            sum_wide[k] = {1'b0, sum_reg[k]} + (SUM_W + 1)'(pval[VAL_W-2:0]);
            sum_next[k] = sum_reg[k];
            cnt_next[k] = cnt_reg[k];
            if (cmd.clear)
            begin
                sum_next[k] = '0;
                cnt_next[k] = '0;
            end
            else if (cmd.acc_en && qual && pmask[k])
            begin
                sum_next[k] = (sum_wide[k] > {1'b0, SUM_MAX}) ? SUM_MAX
                                                                : sum_wide[k][SUM_W-1:0];
                if (cnt_reg[k] != CNT_MAX)
                    cnt_next[k] = cnt_reg[k] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NZONES; k++)
            begin
                sum_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NZONES; k++)
            begin
                sum_reg[k] <= sum_next[k];
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    // restoring divider, one quotient bit a cycle; dividend carries the rounding half
    assign dividend = {1'b0, sum_reg[cmd.zone], {FRAC_W{1'b0}}}
                    + DIV_W'(cnt_reg[cmd.zone] >> 1);
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= cnt_reg[cmd.zone];
            empty_reg   <= (cnt_reg[cmd.zone] == '0);
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], trial_ge};
            rem_reg <= trial_ge ? CNT_W'(trial - {1'b0, divisor_reg}) : trial[CNT_W-1:0];
        end
        if (cmd.div_store)
        begin
            if (empty_reg)
                mean_reg[cmd.zone] <= MEAN_EMPTY;
            else if (quo_reg > MEAN_MAX)
                mean_reg[cmd.zone] <= MEAN_MAX[MEAN_W-1:0];
            else
                mean_reg[cmd.zone] <= quo_reg[MEAN_W-1:0];
        end
        if (cmd.out_load)
        begin
            for (int k = 0; k < NZONES; k++)
                out_data_reg[k*MEAN_W +: MEAN_W] <= mean_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
